### rtl/ottr_pkg.sv
// ----------------------------------------------------------------------------
// ottr_pkg - shared definitions for the octal tree next-hop router
// Widths, fixed addresses and the radio digit table used by the router and
// its channel interfaces.
// ----------------------------------------------------------------------------
package ottr_pkg;

  localparam int unsigned DestW  = 16;
  localparam int unsigned AddrW  = 15;
  localparam int unsigned RadioW = 32;
  localparam int unsigned Digits = 5;

  typedef logic [DestW-1:0]  dest_t;
  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [RadioW-1:0] radio_t;

  localparam addr_t  BCAST_ADDR   = 15'o77777;
  localparam radio_t RADIO_PREFIX = 32'hE330_0000;
  localparam radio_t RADIO_BCAST  = 32'hE333_CCCC;

  // Map one octal digit to its radio nibble.
  function automatic logic [3:0] digit_code(input logic [2:0] d);
    logic [3:0] c;
    case (d)
      3'd0:    c = 4'h3;
      3'd1:    c = 4'hF;
      3'd2:    c = 4'hE;
      3'd3:    c = 4'h6;
      3'd4:    c = 4'h1;
      3'd5:    c = 4'h9;
      3'd6:    c = 4'hB;
      3'd7:    c = 4'h4;
      default: c = 4'h3;
    endcase
    return c;
  endfunction

endpackage

### rtl/ottr_if.sv
// ----------------------------------------------------------------------------
// ottr_if - channel interfaces of the octal tree next-hop router
// Valid/ready channels: destination words in, routing result words out.
// ----------------------------------------------------------------------------
interface ottr_in_if;
  logic            valid;
  logic            ready;
  ottr_pkg::dest_t dest_address;

  modport source (output valid, output dest_address, input ready);
  modport sink   (input valid, input dest_address, output ready);
endinterface

interface ottr_out_if;
  logic             valid;
  logic             ready;
  logic             status;
  ottr_pkg::addr_t  next_hop;
  ottr_pkg::radio_t radio_address;
  logic             is_broadcast;
  logic             is_descendant;
  logic             is_direct_child;

  modport source (output valid, output status, output next_hop, output radio_address,
                  output is_broadcast, output is_descendant, output is_direct_child,
                  input ready);
  modport sink   (input valid, input status, input next_hop, input radio_address,
                  input is_broadcast, input is_descendant, input is_direct_child,
                  output ready);
endinterface

### rtl/octal_tree_next_hop_router_unit.sv
// ----------------------------------------------------------------------------
// octal_tree_next_hop_router_unit - next-hop routing in a five-level octal tree
// Takes a destination word, gives the next hop, its radio address and the
// broadcast, descendant and direct-child flags for the configured host.
// ----------------------------------------------------------------------------
// One destination word is taken every cycle while the result channel does not
// stall. Each word passes through the input register and then the result
// register, and its result word is shown on the result channel from the latter.
// Throughput is one word per cycle while no back-pressure holds the stages,
// set by the single pass of mask and compare logic between those two registers.
// Back-pressure on the result channel holds the result register, and the input
// register too once it is full. The user must write the host address register
// through cfg_wr_en/cfg_wr_data only while no word is in flight; the block
// itself does not enforce this. The register resets to the root (address 0).
// Invalid destinations give status 1 and all other result fields zero.
module octal_tree_next_hop_router_unit (
  input  logic                clk,
  input  logic                rst_n,
  ottr_in_if.sink             in_ch,
  ottr_out_if.source          out_ch,
  input  logic                cfg_wr_en,
  input  ottr_pkg::addr_t     cfg_wr_data
);

  // Host address register.
  ottr_pkg::addr_t host_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      host_r <= '0;
    end else if (cfg_wr_en) begin
      host_r <= cfg_wr_data;
    end
  end

  // Pipeline control: advance the result stage when it is empty or taken,
  // and the input stage when it is empty or moving on.
  logic s1_valid_r, s2_valid_r;
  logic s2_adv, s1_adv;

  assign s2_adv      = !s2_valid_r || out_ch.ready;
  assign s1_adv      = !s1_valid_r || s2_adv;
  assign in_ch.ready = s1_adv;

  ottr_pkg::dest_t dest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_r <= in_ch.valid;
      if (s2_adv) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_ch.valid) begin
      dest_r <= in_ch.dest_address;
    end
  end

  // Digit mask of the host: every digit below its first zero digit.
  ottr_pkg::addr_t mask;
  logic [ottr_pkg::Digits-1:0] host_nz;
  logic [ottr_pkg::Digits-1:0] host_run;

  always_comb begin
    for (int i = 0; i < ottr_pkg::Digits; i++) begin
      host_nz[i] = host_r[3*i +: 3] != 3'd0;
    end
    host_run[0] = host_nz[0];
    for (int i = 1; i < ottr_pkg::Digits; i++) begin
      host_run[i] = host_run[i-1] && host_nz[i];
    end
    for (int i = 0; i < ottr_pkg::Digits; i++) begin
      mask[3*i +: 3] = {3{host_run[i]}};
    end
  end

  // Destination validity: top bit clear, no nonzero digit above a zero one.
  ottr_pkg::addr_t dest;
  logic [ottr_pkg::Digits-1:0] dest_nz;
  logic dest_ok;

  always_comb begin
    dest = dest_r[ottr_pkg::AddrW-1:0];
    for (int i = 0; i < ottr_pkg::Digits; i++) begin
      dest_nz[i] = dest[3*i +: 3] != 3'd0;
    end
    dest_ok = !dest_r[ottr_pkg::DestW-1];
    for (int i = 1; i < ottr_pkg::Digits; i++) begin
      if (dest_nz[i] && !dest_nz[i-1]) dest_ok = 1'b0;
    end
  end

  // Routing decision.
  ottr_pkg::addr_t   child_mask;
  ottr_pkg::addr_t   hop;
  logic [19:0]       codes;
  ottr_pkg::radio_t  radio;
  logic              is_bcast, under, desc, direct;

  always_comb begin
    // One level deeper than the host: its mask plus the next digit.
    child_mask = {mask[ottr_pkg::AddrW-4:0], 3'b111};
    is_bcast   = dest == ottr_pkg::BCAST_ADDR;
    under      = (dest & mask) == host_r;
    desc       = under && (dest != host_r);
    direct     = desc && ((dest & ~child_mask) == '0)
                      && ((dest & {~mask[ottr_pkg::AddrW-4:0], 3'b000}) == '0);

    if (is_bcast) begin
      hop = ottr_pkg::BCAST_ADDR;
    end else if (dest == host_r) begin
      hop = host_r;
    end else if (under) begin
      hop = dest & child_mask;
    end else begin
      // Parent: drop the host's last masked digit.
      hop = host_r & (mask >> 3);
    end

    for (int i = 0; i < ottr_pkg::Digits; i++) begin
      codes[4*i +: 4] = ottr_pkg::digit_code(hop[3*i +: 3]);
    end
    if (hop == ottr_pkg::BCAST_ADDR) begin
      radio = ottr_pkg::RADIO_BCAST;
    end else begin
      radio = ottr_pkg::RADIO_PREFIX | {12'h000, codes};
    end
  end

  // Result register: hold while the sink stalls, zero fields on a bad address.
  logic             status_r, bcast_r, desc_r, direct_r;
  ottr_pkg::addr_t  hop_r;
  ottr_pkg::radio_t radio_r;

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid_r) begin
      status_r <= !dest_ok;
      hop_r    <= dest_ok ? hop   : '0;
      radio_r  <= dest_ok ? radio : '0;
      bcast_r  <= dest_ok && is_bcast;
      desc_r   <= dest_ok && desc;
      direct_r <= dest_ok && direct;
    end
  end

  assign out_ch.valid           = s2_valid_r;
  assign out_ch.status          = status_r;
  assign out_ch.next_hop        = hop_r;
  assign out_ch.radio_address   = radio_r;
  assign out_ch.is_broadcast    = bcast_r;
  assign out_ch.is_descendant   = desc_r;
  assign out_ch.is_direct_child = direct_r;

endmodule
